// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== design/x86asc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86asc_pkg
// Types and constants of the add / sub / cmp flags ALU: operation codes,
// operand widths, flag bit positions and the structs passed between stages.
// ----------------------------------------------------------------------------
package x86asc_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned BYTE_W = 8;

  // Flag bit positions in the flags word.
  localparam int unsigned FLAG_CF = 0;
  localparam int unsigned FLAG_PF = 2;
  localparam int unsigned FLAG_AF = 4;
  localparam int unsigned FLAG_ZF = 6;
  localparam int unsigned FLAG_SF = 7;
  localparam int unsigned FLAG_OF = 11;

  // Operation codes; the last code performs no operation.
  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_SUB  = 2'd1,
    KIND_CMP  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  // One operation held in the input register.
  typedef struct packed {
    kind_t               kind;
    logic                wide;
    logic [DATA_W-1:0]   dst;
    logic [DATA_W-1:0]   src;
    logic [DATA_W-1:0]   flags;
  } op_t;

  // One finished result.
  typedef struct packed {
    logic [DATA_W-1:0]   value;
    logic [DATA_W-1:0]   flags;
  } res_t;

endpackage

// ===== design/x86asc_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86asc_in_stage
// Input register: captures an accepted item and holds it until the result
// register takes the computed result.
// ----------------------------------------------------------------------------
module x86asc_in_stage import x86asc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind,
  input  logic              wide,
  input  logic [DATA_W-1:0] dst_value,
  input  logic [DATA_W-1:0] src_value,
  input  logic [DATA_W-1:0] flags_in,
  input  logic              stage_take,
  output logic              op_valid,
  output op_t               op
);

  // The register frees up when it is empty or its item moves on this cycle.
  assign in_ready = !op_valid || stage_take;

  // Valid bit of the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (in_ready) begin
      op_valid <= in_valid;
    end
  end

  // Operand capture on each accepted item.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op.kind  <= kind_t'(kind);
      op.wide  <= wide;
      op.dst   <= dst_value;
      op.src   <= src_value;
      op.flags <= flags_in;
    end
  end

endmodule

// ===== design/x86asc_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86asc_alu
// Combinational add / subtract with 8086 flag update at byte or word width.
// ----------------------------------------------------------------------------
module x86asc_alu import x86asc_pkg::*; (
  input  op_t  op,
  output res_t res
);

  logic [DATA_W-1:0] dst_m;
  logic [DATA_W-1:0] src_m;
  logic [DATA_W:0]   sum;
  logic [DATA_W:0]   diff;
  logic [DATA_W:0]   full;
  logic [DATA_W-1:0] arith;
  logic              is_add;
  logic              cf;
  logic              of;
  logic              af;
  logic              sf;
  logic              d_top;
  logic              s_top;
  logic              r_top;

  // Operands are cut to the low byte in byte mode.
  assign dst_m = op.wide ? op.dst : {{(DATA_W-BYTE_W){1'b0}}, op.dst[BYTE_W-1:0]};
  assign src_m = op.wide ? op.src : {{(DATA_W-BYTE_W){1'b0}}, op.src[BYTE_W-1:0]};

  // Separate sum and difference paths: sum for add, difference for sub and cmp.
  assign is_add = (op.kind == KIND_ADD);
  assign sum    = {1'b0, dst_m} + {1'b0, src_m};
  assign diff   = {1'b0, dst_m} - {1'b0, src_m};
  assign full   = is_add ? sum : diff;
  assign arith  = op.wide ? full[DATA_W-1:0]
                          : {{(DATA_W-BYTE_W){1'b0}}, full[BYTE_W-1:0]};

  // Carry or borrow out of the operand width; a borrow fills the upper bits.
  assign cf = op.wide ? full[DATA_W] : full[BYTE_W];

  // Signed overflow from the top bits of operands and result.
  assign d_top = op.wide ? dst_m[DATA_W-1] : dst_m[BYTE_W-1];
  assign s_top = op.wide ? src_m[DATA_W-1] : src_m[BYTE_W-1];
  assign r_top = op.wide ? arith[DATA_W-1] : arith[BYTE_W-1];
  assign of    = is_add ? (~(d_top ^ s_top) & (d_top ^ r_top))
                        : ((d_top ^ s_top) & (d_top ^ r_top));
  assign sf    = r_top;

  // Carry or borrow into bit four.
  assign af = dst_m[4] ^ src_m[4] ^ arith[4];

  // Result word and updated flags.
  always_comb begin
    res.value = dst_m;
    res.flags = op.flags;
    unique case (op.kind)
      KIND_ADD, KIND_SUB, KIND_CMP: begin
        res.value          = (op.kind == KIND_CMP) ? dst_m : arith;
        res.flags[FLAG_CF] = cf;
        res.flags[FLAG_PF] = ~^arith[BYTE_W-1:0];
        res.flags[FLAG_AF] = af;
        res.flags[FLAG_ZF] = (arith == '0);
        res.flags[FLAG_SF] = sf;
        res.flags[FLAG_OF] = of;
      end
      KIND_NONE: begin
        res.value = dst_m;
        res.flags = op.flags;
      end
      default: begin
        res.value = dst_m;
        res.flags = op.flags;
      end
    endcase
  end

endmodule

// ===== design/x86asc_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86asc_out_stage
// Result register: holds a finished item until the receiver takes it.
// ----------------------------------------------------------------------------
module x86asc_out_stage import x86asc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  input  res_t              res,
  output logic              stage_take,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] result_value,
  output logic [DATA_W-1:0] flags_out
);

  // Room for a new result when empty or when the held one leaves now.
  assign stage_take = !out_valid || out_ready;

  // Valid bit of the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_take) begin
      out_valid <= op_valid;
    end
  end

  // Result capture.
  always_ff @(posedge clk) begin
    if (stage_take && op_valid) begin
      result_value <= res.value;
      flags_out    <= res.flags;
    end
  end

endmodule

// ===== design/x86_add_sub_cmp_flags_alu_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_add_sub_cmp_flags_alu_core
// 8086-style add / sub / cmp ALU with carry, overflow, auxiliary carry,
// parity, zero and sign flag update at byte or word width.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_ready) carries one item: the operation
//   kind, the width flag, both operands and the current flags word. The
//   output channel (out_valid / out_ready) returns one item per input item:
//   the result word and the updated flags word, in input order.
//   An accepted item passes from the input register into the result register,
//   where out_valid rises; a receiver stall can hold it in the input register.
//   Throughput is one item per cycle while out_ready stays high, set by the
//   single adder pass between the input register and the result register.
//   When the receiver stalls, the result register holds its item and the
//   input register can still take one more item; after that in_ready drops
//   until out_ready returns. No item is lost or repeated.
//   A synchronous reset empties both registers; in_ready is high again
//   once reset is released.
//   In byte mode the upper byte of result_value is zero.
// ----------------------------------------------------------------------------
module x86_add_sub_cmp_flags_alu_core import x86asc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind,
  input  logic              wide,
  input  logic [DATA_W-1:0] dst_value,
  input  logic [DATA_W-1:0] src_value,
  input  logic [DATA_W-1:0] flags_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] result_value,
  output logic [DATA_W-1:0] flags_out
);

  logic op_valid;
  logic stage_take;
  op_t  op;
  res_t res;

  // Input register.
  x86asc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .wide       (wide),
    .dst_value  (dst_value),
    .src_value  (src_value),
    .flags_in   (flags_in),
    .stage_take (stage_take),
    .op_valid   (op_valid),
    .op         (op)
  );

  // Arithmetic and flag logic.
  x86asc_alu u_alu (
    .op  (op),
    .res (res)
  );

  // Result register.
  x86asc_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (op_valid),
    .res          (res),
    .stage_take   (stage_take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .flags_out    (flags_out)
  );

endmodule

// ===== design/x86asc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86asc_checker
// Port-level checks of the ALU core: reset, pipeline progress and the
// holding of a stalled result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module x86asc_checker import x86asc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] result_value,
  input logic [DATA_W-1:0] flags_out
);

  // A stalled result stays put.
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(flags_out), "stalled result changed")

  // Reset empties the result register.
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result valid after reset")

  // With no result waiting, the pipeline can always take an item.
  `ASSERT_CLK(a_ready_when_empty, clk, rst, !out_valid |-> in_ready, "input stalled with empty output")

  // An accepted item reaches the output once the receiver gives room.
  `ASSERT_CLK(a_progress, clk, rst, in_valid && in_ready ##1 out_ready |=> out_valid, "accepted item did not advance")

endmodule

bind x86_add_sub_cmp_flags_alu_core x86asc_checker u_checker (.*);

// ===== verif/x86_add_sub_cmp_flags_alu_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_add_sub_cmp_flags_alu_core_test
// Self-checking bench for the add / sub / cmp flags ALU. A directed set hits
// the carry, borrow, overflow, nibble carry, zero and masking corners; then
// random operations run under three stall mixes on both channels. Every
// accepted item is predicted and each returned result is checked in order.
// ----------------------------------------------------------------------------
module x86_add_sub_cmp_flags_alu_core_test;
  import x86asc_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 12;
  localparam int STALL_LIMIT   = 1000;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 60;
  localparam int PHASE_ITEMS   = 150;

  // Expected results of the accepted operations, oldest first.
  class alu_scoreboard;
    res_t expected_q[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    // Computes the result and flags word that one operation must produce.
    function res_t predict_alu(op_t op);
      logic [DATA_W-1:0] mask;
      logic [DATA_W-1:0] sign;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] r;
      logic [DATA_W:0]   total;
      logic [4:0]        nibble_sum;
      logic              cy;
      logic              ov;
      logic              ac;
      res_t              res;
      mask = op.wide ? 16'hFFFF : 16'h00FF;
      sign = op.wide ? 16'h8000 : 16'h0080;
      a    = op.dst & mask;
      b    = op.src & mask;
      res.flags = op.flags;
      if (op.kind == KIND_NONE) begin
        res.value = a;
        return res;
      end
      if (op.kind == KIND_ADD) begin
        total      = {1'b0, a} + {1'b0, b};
        r          = total[DATA_W-1:0] & mask;
        cy         = total > {1'b0, mask};
        ov         = |(~(a ^ b) & (a ^ r) & sign);
        nibble_sum = {1'b0, a[3:0]} + {1'b0, b[3:0]};
        ac         = nibble_sum[4];
      end else begin
        r  = (a - b) & mask;
        cy = b > a;
        ov = |((a ^ b) & (a ^ r) & sign);
        ac = b[3:0] > a[3:0];
      end
      res.flags[FLAG_CF] = cy;
      res.flags[FLAG_PF] = ~^r[7:0];
      res.flags[FLAG_AF] = ac;
      res.flags[FLAG_ZF] = (r == '0);
      res.flags[FLAG_SF] = |(r & sign);
      res.flags[FLAG_OF] = ov;
      res.value = (op.kind == KIND_CMP) ? a : r;
      return res;
    endfunction

    function void note_op(op_t op);
      expected_q.push_back(predict_alu(op));
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Compares one returned item with the oldest expectation.
    task check_result(logic [DATA_W-1:0] value, logic [DATA_W-1:0] flags);
      res_t exp_res;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %h/%h with nothing expected", value, flags));
        return;
      end
      exp_res = expected_q.pop_front();
      if (value !== exp_res.value)
        report_mismatch($sformatf("result_value %h, expected %h", value, exp_res.value));
      if (flags !== exp_res.flags)
        report_mismatch($sformatf("flags_out %h, expected %h", flags, exp_res.flags));
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        kind;
  logic              wide;
  logic [DATA_W-1:0] dst_value;
  logic [DATA_W-1:0] src_value;
  logic [DATA_W-1:0] flags_in;
  logic              out_valid;
  logic              out_ready;
  logic [DATA_W-1:0] result_value;
  logic [DATA_W-1:0] flags_out;

  alu_scoreboard sb = new();

  int send_idle_pct;
  int recv_idle_pct;
  bit long_hold_req;
  int stall_cycles;

  x86_add_sub_cmp_flags_alu_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .wide         (wide),
    .dst_value    (dst_value),
    .src_value    (src_value),
    .flags_in     (flags_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .flags_out    (flags_out)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // Receiver: random back-pressure, or a long hold when one is requested.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Check every returned item.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(result_value, flags_out);
  end

  // Watchdog on cycles where neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function op_t make_op(kind_t k, logic w, logic [15:0] d, logic [15:0] s, logic [15:0] f);
    op_t op;
    op.kind  = k;
    op.wide  = w;
    op.dst   = d;
    op.src   = s;
    op.flags = f;
    return op;
  endfunction

  // Operand values lean toward the sign and nibble boundaries.
  function logic [15:0] rand_operand();
    case ($urandom_range(11))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return {8'($urandom), 8'h7F};
      3:       return {8'($urandom), 8'h80};
      4:       return 16'h7FFF;
      5:       return 16'h8000;
      6:       return {12'($urandom), 4'hF};
      default: return 16'($urandom);
    endcase
  endfunction

  function op_t random_op();
    kind_t k;
    int    pick;
    pick = $urandom_range(15);
    if (pick < 5)       k = KIND_ADD;
    else if (pick < 10) k = KIND_SUB;
    else if (pick < 15) k = KIND_CMP;
    else                k = KIND_NONE;
    return make_op(k, 1'($urandom), rand_operand(), rand_operand(), 16'($urandom));
  endfunction

  // Presents one item from a falling edge and holds it until accepted.
  task send_op(op_t op);
    in_valid  <= 1'b1;
    kind      <= op.kind;
    wide      <= op.wide;
    dst_value <= op.dst;
    src_value <= op.src;
    flags_in  <= op.flags;
    do @(posedge clk); while (!in_ready);
    sb.note_op(op);
    @(negedge clk);
  endtask

  // Random idle cycles on the input side after an item.
  task sender_gap();
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Stops offering items until every expected result has come back.
  task wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.outstanding() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task run_random(int count);
    for (int i = 0; i < count; i++) begin
      send_op(random_op());
      sender_gap();
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    kind          = KIND_ADD;
    wide          = 1'b0;
    dst_value     = '0;
    src_value     = '0;
    flags_in      = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req = 1'b0;
    stall_cycles  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corners: carries, borrows, overflow, nibble carry, zero,
    // byte masking with live upper bytes, and the no-operation code.
    send_op(make_op(KIND_ADD,  1'b0, 16'h00FF, 16'h0001, 16'h0000));
    send_op(make_op(KIND_ADD,  1'b0, 16'h007F, 16'h0001, 16'hFFFF));
    send_op(make_op(KIND_ADD,  1'b1, 16'hFFFF, 16'h0001, 16'h0000));
    send_op(make_op(KIND_ADD,  1'b1, 16'h7FFF, 16'h0001, 16'h0000));
    send_op(make_op(KIND_ADD,  1'b1, 16'h8000, 16'h8000, 16'hF72A));
    send_op(make_op(KIND_ADD,  1'b0, 16'hA5F0, 16'h5A10, 16'h0000));
    send_op(make_op(KIND_ADD,  1'b0, 16'h000F, 16'h0001, 16'h0000));
    send_op(make_op(KIND_SUB,  1'b0, 16'h0080, 16'h0001, 16'h0000));
    send_op(make_op(KIND_SUB,  1'b1, 16'h8000, 16'h0001, 16'hFFFF));
    send_op(make_op(KIND_SUB,  1'b0, 16'hFF00, 16'h0001, 16'h0000));
    send_op(make_op(KIND_SUB,  1'b1, 16'h0000, 16'hFFFF, 16'h0000));
    send_op(make_op(KIND_SUB,  1'b1, 16'h1234, 16'h1234, 16'h0000));
    send_op(make_op(KIND_SUB,  1'b0, 16'h0010, 16'h0001, 16'h0000));
    send_op(make_op(KIND_SUB,  1'b0, 16'h007F, 16'h00FF, 16'h0000));
    send_op(make_op(KIND_CMP,  1'b1, 16'h0005, 16'h0007, 16'h0000));
    send_op(make_op(KIND_CMP,  1'b0, 16'h1280, 16'h3480, 16'hFFFF));
    send_op(make_op(KIND_CMP,  1'b1, 16'h8000, 16'h7FFF, 16'h0000));
    send_op(make_op(KIND_NONE, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_op(make_op(KIND_NONE, 1'b1, 16'hABCD, 16'h1234, 16'h0000));
    send_op(make_op(KIND_ADD,  1'b1, 16'h0000, 16'h0000, 16'hFFFF));
    send_op(make_op(KIND_SUB,  1'b1, 16'hFFFF, 16'h0000, 16'h0000));
    send_op(make_op(KIND_CMP,  1'b0, 16'h00FF, 16'h0000, 16'h5555));
    wait_drained();

    // Light sender gaps against a heavily stalling receiver.
    send_idle_pct = 15;
    recv_idle_pct = 63;
    run_random(PHASE_ITEMS);
    wait_drained();

    // Heavy sender gaps against a mostly ready receiver.
    send_idle_pct = 63;
    recv_idle_pct = 15;
    run_random(PHASE_ITEMS / 2);
    wait_drained();
    run_random(PHASE_ITEMS / 2);
    wait_drained();

    // Back to back, with one long receiver hold that fills the block.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_ITEMS / 3);
    long_hold_req = 1'b1;
    run_random(PHASE_ITEMS - PHASE_ITEMS / 3);
    wait_drained();

    if (sb.outstanding() != 0)
      sb.report_mismatch($sformatf("%0d expected results never came", sb.outstanding()));
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
